@@ rtl/core/max_pooling_2d_backward_unit_defines.svh @@
// Assertion macros shared by the checker of the max-pool backward unit.
`ifndef MAX_POOLING_2D_BACKWARD_UNIT_DEFINES_SVH
`define MAX_POOLING_2D_BACKWARD_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mpb_pkg.sv @@
// Package with the types, codes and constants of the max-pool backward unit.
`default_nettype none
package mpb_pkg;

  localparam int MPB_MAX_ROWS = 64;
  localparam int MPB_MAX_COLS = 64;
  localparam int VALUE_BITS = 16;
  localparam int ACC_BITS = 24;

  typedef enum logic [2:0] {
    CMD_LOAD_SAMPLE = 3'd0,
    CMD_LOAD_OGRAD  = 3'd1,
    CMD_LOAD_IGRAD  = 3'd2,
    CMD_RUN         = 3'd3,
    CMD_READ        = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_INPUT_HEIGHT  = 3'd0,
    REG_INPUT_WIDTH   = 3'd1,
    REG_FILTER_HEIGHT = 3'd2,
    REG_FILTER_WIDTH  = 3'd3,
    REG_STRIDE_ROWS   = 3'd4,
    REG_STRIDE_COLS   = 3'd5,
    REG_COVERED_MODE  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_WIN,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_ACC
  } state_t;

  typedef struct packed {
    logic [2:0]                   command;
    logic [11:0]                  address;
    logic signed [VALUE_BITS-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] read_value;
    logic                       saturated;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/max_pooling_2d_backward_unit.sv @@
// Max-pool backward unit: one channel plane held in three RAMs, run by a sequencer.
// Loads and reads take one item per cycle while the unit is not busy; the result strobe
// comes in the cycle after accept. A run first sizes the output, then per window scans
// its cells via the single read port of the sample RAM, then drains, fetches, accumulates.
// An invalid run answers in the cycle after accept with the saturation flag cleared.
// Synchronous reset clears the sequencer and the flag, and sets the config registers to their defaults;
// RAM contents are not cleared and are undefined until written.
`default_nettype none
module max_pooling_2d_backward_unit import mpb_pkg::*; #(
  parameter int MAX_ROWS = MPB_MAX_ROWS,
  parameter int MAX_COLS = MPB_MAX_COLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_item_t   item,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic [6:0] cfg_ih, cfg_iw, cfg_fh, cfg_fw, cfg_sy, cfg_sx;
  logic       cfg_cov;

  // Sequencer state and run bookkeeping.
  state_t state, state_next;
  logic [6:0] oh, ow;          // output rows and columns
  logic [7:0] acc_y, acc_x;    // last window offset found during sizing
  logic [7:0] lim_y, lim_x;    // largest allowed window offset
  logic [6:0] left;            // left padding
  logic [6:0] h, w;            // current output position
  logic signed [9:0] wr0, wc0; // unclipped window origin
  logic [6:0] rs, re, cs, ce;  // clipped window bounds
  logic [6:0] r, c;            // scan position
  logic [AW-1:0] og_idx;       // output gradient index h*ow+w

  // Max search pipeline, one stage behind the sample RAM read.
  logic          p_valid, p_first;
  logic [AW-1:0] p_addr;
  logic signed [VALUE_BITS-1:0] best_val;
  logic [AW-1:0] best_addr;

  logic clip;
  logic rd_sel;

  // RAM ports.
  logic          s_en, s_we, g_en, g_we, i_en, i_we;
  logic [AW-1:0] s_addr, g_addr, i_addr;
  logic [VALUE_BITS-1:0] s_q, g_q;
  logic [ACC_BITS-1:0]   i_q, i_wdata;

  logic accept, addr_ok, run_ok, cfg_wr;
  logic [AW-1:0] cmd_addr;

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign addr_ok = (32'(item.address) < 32'(DEPTH));
  assign cmd_addr = AW'(item.address);
  assign cfg_wr = psel && penable && pwrite;

  // A run is legal only with nonzero sizes and strides, an input inside the stores and a
  // filter no larger than the input.
  assign run_ok = (cfg_ih != 7'd0) && (cfg_iw != 7'd0) && (cfg_fh != 7'd0) &&
                  (cfg_fw != 7'd0) && (cfg_sy != 7'd0) && (cfg_sx != 7'd0) &&
                  (32'(cfg_ih) <= 32'(MAX_ROWS)) && (32'(cfg_iw) <= 32'(MAX_COLS)) &&
                  (cfg_fh <= cfg_ih) && (cfg_fw <= cfg_iw);

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ih  <= 7'd8;
      cfg_iw  <= 7'd8;
      cfg_fh  <= 7'd2;
      cfg_fw  <= 7'd2;
      cfg_sy  <= 7'd2;
      cfg_sx  <= 7'd2;
      cfg_cov <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_INPUT_HEIGHT:  cfg_ih  <= pwdata[6:0];
        REG_INPUT_WIDTH:   cfg_iw  <= pwdata[6:0];
        REG_FILTER_HEIGHT: cfg_fh  <= pwdata[6:0];
        REG_FILTER_WIDTH:  cfg_fw  <= pwdata[6:0];
        REG_STRIDE_ROWS:   cfg_sy  <= pwdata[6:0];
        REG_STRIDE_COLS:   cfg_sx  <= pwdata[6:0];
        REG_COVERED_MODE:  cfg_cov <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (paddr[4:2])
      REG_INPUT_HEIGHT:  prdata = 32'(cfg_ih);
      REG_INPUT_WIDTH:   prdata = 32'(cfg_iw);
      REG_FILTER_HEIGHT: prdata = 32'(cfg_fh);
      REG_FILTER_WIDTH:  prdata = 32'(cfg_fw);
      REG_STRIDE_ROWS:   prdata = 32'(cfg_sy);
      REG_STRIDE_COLS:   prdata = 32'(cfg_sx);
      REG_COVERED_MODE:  prdata = 32'(cfg_cov);
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sizing: the output size is the count of window offsets k*stride that stay at
  // or below the limit, found by stepping one stride per cycle.
  // ---------------------------------------------------------------------------
  logic step_y, step_x;
  logic signed [9:0] pad_y, pad_x;
  logic [6:0] top_n, left_n;

  assign step_y = ({1'b0, acc_y} + 9'(cfg_sy)) <= {1'b0, lim_y};
  assign step_x = ({1'b0, acc_x} + 9'(cfg_sx)) <= {1'b0, lim_x};
  assign pad_y = $signed(10'(acc_y)) + $signed(10'(cfg_fh)) - $signed(10'(cfg_ih));
  assign pad_x = $signed(10'(acc_x)) + $signed(10'(cfg_fw)) - $signed(10'(cfg_iw));
  assign top_n  = pad_y[9] ? 7'd0 : pad_y[7:1];
  assign left_n = pad_x[9] ? 7'd0 : pad_x[7:1];

  // ---------------------------------------------------------------------------
  // Window clipping against the input plane.
  // ---------------------------------------------------------------------------
  logic signed [9:0] rs_v, re_v, cs_v, ce_v, wr1, wc1;
  logic win_empty;

  assign wr1  = wr0 + $signed(10'(cfg_fh));
  assign wc1  = wc0 + $signed(10'(cfg_fw));
  assign rs_v = wr0[9] ? 10'sd0 : wr0;
  assign cs_v = wc0[9] ? 10'sd0 : wc0;
  assign re_v = (wr1 > $signed(10'(cfg_ih))) ? $signed(10'(cfg_ih)) : wr1;
  assign ce_v = (wc1 > $signed(10'(cfg_iw))) ? $signed(10'(cfg_iw)) : wc1;
  assign win_empty = (rs_v >= re_v) || (cs_v >= ce_v);

  // Position advance after a window is finished or skipped.
  logic last_w, last_h;
  assign last_w = (w + 7'd1 == ow);
  assign last_h = (h + 7'd1 == oh);

  // Scan address and wrap of the scan position.
  logic [13:0] scan_lin;
  logic scan_col_end, scan_row_end;
  assign scan_lin = 14'(r) * 14'(cfg_iw) + 14'(c);
  assign scan_col_end = (c + 7'd1 == ce);
  assign scan_row_end = (r + 7'd1 == re);

  // Accumulation with saturation to the Q15.8 range.
  logic signed [ACC_BITS:0] sum;
  logic sat;
  assign sum = $signed({i_q[ACC_BITS-1], i_q}) +
               $signed({{(ACC_BITS+1-VALUE_BITS){g_q[VALUE_BITS-1]}}, g_q});
  assign sat = (sum[ACC_BITS] != sum[ACC_BITS-1]);

  always_comb begin
    if (!sat) begin
      i_wdata = sum[ACC_BITS-1:0];
    end else if (sum[ACC_BITS]) begin
      i_wdata = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      i_wdata = {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Next state and RAM port control.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    s_en = 1'b0; s_we = 1'b0; s_addr = cmd_addr;
    g_en = 1'b0; g_we = 1'b0; g_addr = cmd_addr;
    i_en = 1'b0; i_we = 1'b0; i_addr = cmd_addr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.command)
            CMD_LOAD_SAMPLE: begin
              s_en = addr_ok;
              s_we = 1'b1;
            end
            CMD_LOAD_OGRAD: begin
              g_en = addr_ok;
              g_we = 1'b1;
            end
            CMD_LOAD_IGRAD: begin
              i_en = addr_ok;
              i_we = 1'b1;
            end
            CMD_READ: begin
              i_en = addr_ok;
            end
            CMD_RUN: begin
              if (run_ok) begin
                state_next = S_SIZE;
              end
            end
            default: ;
          endcase
        end
      end
      S_SIZE: begin
        if (!step_y && !step_x) begin
          state_next = S_WIN;
        end
      end
      S_WIN: begin
        if (!win_empty) begin
          state_next = S_SCAN;
        end else if (last_w && last_h) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        s_en = 1'b1;
        s_addr = AW'(scan_lin);
        if (scan_col_end && scan_row_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FETCH;
      end
      S_FETCH: begin
        i_en = 1'b1;
        i_addr = best_addr;
        g_en = 1'b1;
        g_addr = og_idx;
        state_next = S_ACC;
      end
      S_ACC: begin
        i_en = 1'b1;
        i_we = 1'b1;
        i_addr = best_addr;
        state_next = (last_w && last_h) ? S_IDLE : S_WIN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers.
  // ---------------------------------------------------------------------------
  logic advance;
  assign advance = ((state == S_WIN) && win_empty) || (state == S_ACC);

  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      rd_sel  <= 1'b0;
      clip    <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_sel  <= 1'b0;
      p_valid <= (state == S_SCAN);
      if (accept) begin
        if (item.command == CMD_RUN) begin
          clip <= 1'b0;
          done <= !run_ok;
        end else begin
          done   <= 1'b1;
          rd_sel <= (item.command == CMD_READ) && addr_ok;
        end
      end
      if ((state == S_ACC) && sat) begin
        clip <= 1'b1;
      end
      // The run answers once its last window has been handled.
      if (advance && last_w && last_h) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (item.command == CMD_RUN)) begin
      acc_y <= 8'd0;
      acc_x <= 8'd0;
      oh    <= 7'd1;
      ow    <= 7'd1;
      lim_y <= 8'(cfg_ih - cfg_fh) + (cfg_cov ? 8'(cfg_sy - 7'd1) : 8'd0);
      lim_x <= 8'(cfg_iw - cfg_fw) + (cfg_cov ? 8'(cfg_sx - 7'd1) : 8'd0);
    end

    if (state == S_SIZE) begin
      if (step_y) begin
        acc_y <= acc_y + 8'(cfg_sy);
        oh    <= oh + 7'd1;
      end
      if (step_x) begin
        acc_x <= acc_x + 8'(cfg_sx);
        ow    <= ow + 7'd1;
      end
      if (!step_y && !step_x) begin
        left   <= left_n;
        wr0    <= 10'sd0 - $signed(10'(top_n));
        wc0    <= 10'sd0 - $signed(10'(left_n));
        h      <= 7'd0;
        w      <= 7'd0;
        og_idx <= '0;
      end
    end

    if ((state == S_WIN) && !win_empty) begin
      rs <= rs_v[6:0];
      re <= re_v[6:0];
      cs <= cs_v[6:0];
      ce <= ce_v[6:0];
      r  <= rs_v[6:0];
      c  <= cs_v[6:0];
    end

    if (state == S_SCAN) begin
      p_addr  <= AW'(scan_lin);
      p_first <= (r == rs) && (c == cs);
      if (scan_col_end) begin
        c <= cs;
        r <= r + 7'd1;
      end else begin
        c <= c + 7'd1;
      end
    end

    // Keep the first strict maximum in row-major order.
    if (p_valid) begin
      if (p_first || ($signed(s_q) > best_val)) begin
        best_val  <= $signed(s_q);
        best_addr <= p_addr;
      end
    end

    if (advance) begin
      og_idx <= og_idx + AW'(1);
      if (last_w) begin
        w   <= 7'd0;
        wc0 <= 10'sd0 - $signed(10'(left));
        h   <= h + 7'd1;
        wr0 <= wr0 + $signed(10'(cfg_sy));
      end else begin
        w   <= w + 7'd1;
        wc0 <= wc0 + $signed(10'(cfg_sx));
      end
    end
  end

  assign result.read_value = (done && rd_sel) ? $signed(i_q) : '0;
  assign result.saturated  = clip;

  // ---------------------------------------------------------------------------
  // Plane stores.
  // ---------------------------------------------------------------------------
  mpb_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH), .AW(AW)) u_sample_ram (
    .clk(clk), .en(s_en), .we(s_we), .addr(s_addr), .wdata(item.value), .rdata(s_q)
  );

  mpb_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH), .AW(AW)) u_ograd_ram (
    .clk(clk), .en(g_en), .we(g_we), .addr(g_addr), .wdata(item.value), .rdata(g_q)
  );

  logic [ACC_BITS-1:0] i_din;
  assign i_din = (state == S_ACC) ? i_wdata :
                 {{(ACC_BITS-VALUE_BITS){item.value[VALUE_BITS-1]}}, item.value};

  mpb_ram #(.WIDTH(ACC_BITS), .DEPTH(DEPTH), .AW(AW)) u_igrad_ram (
    .clk(clk), .en(i_en), .we(i_we), .addr(i_addr), .wdata(i_din), .rdata(i_q)
  );

endmodule
`default_nettype wire

@@ rtl/core/mpb_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none
module mpb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/mpb_checker.sv @@
// Port-level checker for the max-pool backward unit and its bind.
`default_nettype none
`include "max_pooling_2d_backward_unit_defines.svh"
module mpb_checker import mpb_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire cmd_item_t   item,
  input wire logic        done,
  input wire result_t     result,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [4:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  logic acc_run, acc_other;
  assign acc_run   = start && !busy && (item.command == CMD_RUN);
  assign acc_other = start && !busy && (item.command != CMD_RUN);

  // Every item other than a run answers in the next cycle.
  `MPB_ASSERT_NEXT(a_quick_answer, acc_other, done, "load or read gave no result")
  // A run clears the saturation flag at once.
  `MPB_ASSERT_NEXT(a_run_clears, acc_run, !result.saturated, "flag not cleared by run")
  // Only a run makes the unit busy.
  `MPB_ASSERT_NOW(a_busy_cause, $rose(busy), $past(acc_run), "busy without a run")
  // Result data is zero outside a result cycle.
  `MPB_ASSERT_NOW(a_idle_zero, !done, result.read_value == '0, "data without strobe")

endmodule

bind max_pooling_2d_backward_unit mpb_checker u_mpb_checker (.*);
`default_nettype wire

@@ test/max_pooling_2d_backward_unit_tb.sv @@
// Self-checking testbench for the max-pool backward unit: directed table, then random phases.
`default_nettype none
module max_pooling_2d_backward_unit_tb;
  import mpb_pkg::*;

  // Command codes 5 to 7 have no meaning; the unit must answer them with zero.
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
  localparam int PLANE_DEPTH = MPB_MAX_ROWS * MPB_MAX_COLS;
  localparam int ITEM_TARGET = 1050;
  localparam longint GRAD_MAX = (64'sd1 <<< (ACC_BITS - 1)) - 1;
  localparam longint GRAD_MIN = -GRAD_MAX - 1;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_item_t   item;
  logic        done;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  max_pooling_2d_backward_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mirror of the unit: three stores, the sticky clip flag and the seven settings.
  logic signed [VALUE_BITS-1:0] sample_mem [PLANE_DEPTH];
  logic signed [VALUE_BITS-1:0] ograd_mem  [PLANE_DEPTH];
  logic signed [ACC_BITS-1:0]   igrad_mem  [PLANE_DEPTH];
  bit   igrad_known [PLANE_DEPTH];
  int   igrad_addrs [$];
  bit   clip_seen;
  int   pool_cfg [7];

  result_t due_results [$];
  int  items_sent;
  int  mismatches;
  bit  steady_feed;

  // Output size of the pool under the current settings; only meaningful when they are valid.
  function automatic void pool_out_size(output int oh, output int ow);
    int ih, iw, fh, fw, sy, sx;
    ih = pool_cfg[REG_INPUT_HEIGHT];  iw = pool_cfg[REG_INPUT_WIDTH];
    fh = pool_cfg[REG_FILTER_HEIGHT]; fw = pool_cfg[REG_FILTER_WIDTH];
    sy = pool_cfg[REG_STRIDE_ROWS];   sx = pool_cfg[REG_STRIDE_COLS];
    if (pool_cfg[REG_COVERED_MODE] != 0) begin
      oh = (ih - fh + sy - 1) / sy + 1;
      ow = (iw - fw + sx - 1) / sx + 1;
    end else begin
      oh = (ih - fh) / sy + 1;
      ow = (iw - fw) / sx + 1;
    end
  endfunction

  function automatic bit pool_cfg_valid();
    int k;
    for (k = 0; k < 6; k++)
      if (pool_cfg[k] == 0) return 1'b0;
    return pool_cfg[REG_INPUT_HEIGHT] <= MPB_MAX_ROWS && pool_cfg[REG_INPUT_WIDTH] <= MPB_MAX_COLS
      && pool_cfg[REG_FILTER_HEIGHT] <= pool_cfg[REG_INPUT_HEIGHT]
      && pool_cfg[REG_FILTER_WIDTH] <= pool_cfg[REG_INPUT_WIDTH];
  endfunction

  // One backward pass: every output gradient lands on the first strict maximum of its window.
  function automatic void pool_backward_pass();
    int ih, iw, fh, fw, sy, sx, oh, ow, pad_y, pad_x, top, left;
    int h, w, r, c, r0, c0, r1, c1, br, bc;
    longint best, acc;
    clip_seen = 1'b0;
    if (!pool_cfg_valid()) return;
    ih = pool_cfg[REG_INPUT_HEIGHT];  iw = pool_cfg[REG_INPUT_WIDTH];
    fh = pool_cfg[REG_FILTER_HEIGHT]; fw = pool_cfg[REG_FILTER_WIDTH];
    sy = pool_cfg[REG_STRIDE_ROWS];   sx = pool_cfg[REG_STRIDE_COLS];
    pool_out_size(oh, ow);
    pad_y = (oh - 1) * sy + fh - ih;
    pad_x = (ow - 1) * sx + fw - iw;
    if (pad_y < 0) pad_y = 0;
    if (pad_x < 0) pad_x = 0;
    top = -(pad_y / 2);
    left = -(pad_x / 2);
    for (h = 0; h < oh; h++) begin
      for (w = 0; w < ow; w++) begin
        r0 = top + h * sy;  c0 = left + w * sx;
        r1 = r0 + fh;       c1 = c0 + fw;
        if (r0 < 0) r0 = 0;
        if (c0 < 0) c0 = 0;
        if (r1 > ih) r1 = ih;
        if (c1 > iw) c1 = iw;
        if (r0 >= r1 || c0 >= c1) continue;
        br = r0;  bc = c0;
        best = sample_mem[r0 * iw + c0];
        for (r = r0; r < r1; r++)
          for (c = c0; c < c1; c++)
            if (longint'(sample_mem[r * iw + c]) > best) begin
              best = sample_mem[r * iw + c];
              br = r;
              bc = c;
            end
        acc = longint'(igrad_mem[br * iw + bc]) + longint'(ograd_mem[(h * ow + w) % PLANE_DEPTH]);
        if (acc > GRAD_MAX) begin
          acc = GRAD_MAX;
          clip_seen = 1'b1;
        end
        if (acc < GRAD_MIN) begin
          acc = GRAD_MIN;
          clip_seen = 1'b1;
        end
        igrad_mem[br * iw + bc] = acc[ACC_BITS-1:0];
      end
    end
  endfunction

  // Applies one accepted item to the mirror and returns the result it must produce.
  function automatic result_t apply_pool_item(cmd_item_t it);
    result_t r;
    r.read_value = '0;
    case (it.command)
      CMD_LOAD_SAMPLE: sample_mem[it.address] = it.value;
      CMD_LOAD_OGRAD:  ograd_mem[it.address] = it.value;
      CMD_LOAD_IGRAD: begin
        igrad_mem[it.address] = ACC_BITS'(it.value);
        if (!igrad_known[it.address]) igrad_addrs.push_back(it.address);
        igrad_known[it.address] = 1'b1;
      end
      CMD_RUN:  pool_backward_pass();
      CMD_READ: r.read_value = igrad_mem[it.address];
      default: ;
    endcase
    r.saturated = clip_seen;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none at all during steady stretches.
  function automatic int pick_gap();
    int p;
    if (steady_feed) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Holds the item until the unit takes it, then books the expected result.
  task automatic send_item(input cmd_item_t it, input bit typed, input result_t want);
    int gap;
    result_t predicted;
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predicted = apply_pool_item(it);
    due_results.push_back(typed ? want : predicted);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input int addr, input int val);
    cmd_item_t it;
    it.command = cmd;
    it.address = addr[11:0];
    it.value = val[VALUE_BITS-1:0];
    send_item(it, 1'b0, '0);
  endtask

  // Stops feeding until every booked result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool_cfg[idx] = (idx == REG_COVERED_MODE) ? (val & 1) : (val & 32'h7f);
  endtask

  // New settings are only written while the unit is idle.
  task automatic set_pool(input int ih, input int iw, input int fh, input int fw,
                          input int sy, input int sx, input int cov);
    drain_results();
    repeat (4) @(posedge clk);
    write_reg(REG_INPUT_HEIGHT, ih);
    write_reg(REG_INPUT_WIDTH, iw);
    write_reg(REG_FILTER_HEIGHT, fh);
    write_reg(REG_FILTER_WIDTH, fw);
    write_reg(REG_STRIDE_ROWS, sy);
    write_reg(REG_STRIDE_COLS, sx);
    write_reg(REG_COVERED_MODE, cov);
  endtask

  // Samples are often drawn from a tiny set so that ties inside a window are common.
  function automatic int pick_sample();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 2) - 1;
    return $urandom_range(0, 65535);
  endfunction

  // Fills every store entry that a run under the current settings will touch.
  task automatic load_planes();
    int oh, ow, a;
    pool_out_size(oh, ow);
    for (a = 0; a < pool_cfg[REG_INPUT_HEIGHT] * pool_cfg[REG_INPUT_WIDTH]; a++)
      send_cmd(CMD_LOAD_SAMPLE, a, pick_sample());
    for (a = 0; a < oh * ow; a++)
      send_cmd(CMD_LOAD_OGRAD, a, $urandom_range(0, 65535));
    for (a = 0; a < pool_cfg[REG_INPUT_HEIGHT] * pool_cfg[REG_INPUT_WIDTH]; a++)
      send_cmd(CMD_LOAD_IGRAD, a, $urandom_range(0, 65535));
  endtask

  // Reads, unused codes and stray loads anywhere in the address space.
  task automatic send_noise(input int count);
    int k, p;
    for (k = 0; k < count; k++) begin
      p = $urandom_range(0, 9);
      if (p < 5 && igrad_addrs.size() != 0)
        send_cmd(CMD_READ, igrad_addrs[$urandom_range(0, igrad_addrs.size() - 1)], 0);
      else if (p < 7)
        send_cmd(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), $urandom_range(0, 4095),
                 $urandom_range(0, 65535));
      else
        send_cmd(3'($urandom_range(CMD_LOAD_SAMPLE, CMD_LOAD_IGRAD)), $urandom_range(0, 4095),
                 $urandom_range(0, 65535));
    end
  endtask

  // Reads back about two in three of the input gradients of the plane, picked at random.
  task automatic read_plane();
    int a;
    for (a = 0; a < pool_cfg[REG_INPUT_HEIGHT] * pool_cfg[REG_INPUT_WIDTH]; a++)
      if ($urandom_range(0, 2) != 0) send_cmd(CMD_READ, a, 0);
  endtask

  // A centered peak sits in every window, so repeated runs drive its gradient into the clamp.
  task automatic saturate_phase();
    int a, k, grad;
    set_pool(11, 11, 6, 6, 1, 1, 0);
    grad = $urandom_range(0, 1) ? 32767 : -32768;
    for (a = 0; a < 121; a++)
      send_cmd(CMD_LOAD_SAMPLE, a, (a == 5 * 11 + 5) ? 32767 : $urandom_range(0, 200) - 100);
    for (a = 0; a < 36; a++)
      send_cmd(CMD_LOAD_OGRAD, a, grad);
    for (a = 0; a < 121; a++)
      send_cmd(CMD_LOAD_IGRAD, a, $urandom_range(0, 65535));
    for (k = 0; k < 9; k++) begin
      send_cmd(CMD_RUN, 0, 0);
      send_cmd(CMD_READ, 5 * 11 + 5, 0);
      send_noise(2);
    end
  endtask

  // Directed table: an expectation is typed in only where it is plain without computing.
  typedef struct {
    cmd_item_t it;
    bit        typed;
    result_t   want;
  } pool_row_t;

  function automatic pool_row_t row(input logic [2:0] cmd, input int addr, input int val,
                                    input bit typed, input int rd, input bit sat);
    pool_row_t r;
    r.it.command = cmd;
    r.it.address = addr[11:0];
    r.it.value = val[VALUE_BITS-1:0];
    r.typed = typed;
    r.want.read_value = rd[ACC_BITS-1:0];
    r.want.saturated = sat;
    return r;
  endfunction

  pool_row_t pool_table [$];

  // Checks each strobed result against the oldest booked expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0h", result);
      end else begin
        if (result.read_value !== due_results[0].read_value
            || result.saturated !== due_results[0].saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: read_value exp %0h got %0h, saturated exp %0b got %0b",
                     due_results[0].read_value, result.read_value,
                     due_results[0].saturated, result.saturated);
        end
        void'(due_results.pop_front());
      end
    end
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int k, p, ih, iw;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_sent = 0;
    mismatches = 0;
    steady_feed = 1'b0;
    clip_seen = 1'b0;
    pool_cfg = '{8, 8, 2, 2, 2, 2, 0};
    for (k = 0; k < PLANE_DEPTH; k++) begin
      sample_mem[k] = '0;
      ograd_mem[k] = '0;
      igrad_mem[k] = '0;
      igrad_known[k] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A 2x2 plane with one 2x2 window: the tie between two equal maxima goes to the first.
    set_pool(2, 2, 2, 2, 1, 1, 0);
    pool_table.push_back(row(CMD_LOAD_SAMPLE, 0, -32768, 1, 0, 0));
    pool_table.push_back(row(CMD_LOAD_SAMPLE, 1, 32767, 1, 0, 0));
    pool_table.push_back(row(CMD_LOAD_SAMPLE, 2, 0, 1, 0, 0));
    pool_table.push_back(row(CMD_LOAD_SAMPLE, 3, 32767, 1, 0, 0));
    pool_table.push_back(row(CMD_LOAD_OGRAD, 0, 32767, 1, 0, 0));
    pool_table.push_back(row(CMD_LOAD_IGRAD, 0, -32768, 1, 0, 0));
    pool_table.push_back(row(CMD_LOAD_IGRAD, 1, 32767, 1, 0, 0));
    pool_table.push_back(row(CMD_LOAD_IGRAD, 2, 0, 1, 0, 0));
    pool_table.push_back(row(CMD_LOAD_IGRAD, 3, -1, 1, 0, 0));
    pool_table.push_back(row(CMD_READ, 1, 0, 1, 32767, 0));
    pool_table.push_back(row(CMD_READ, 3, 0, 1, -1, 0));
    pool_table.push_back(row(CMD_RUN, 0, 0, 0, 0, 0));
    pool_table.push_back(row(CMD_READ, 1, 0, 0, 0, 0));
    pool_table.push_back(row(CMD_READ, 3, 0, 0, 0, 0));
    pool_table.push_back(row(CMD_READ, 0, 0, 1, -32768, 0));
    pool_table.push_back(row(CMD_SPARE_LO, 7, 5, 1, 0, 0));
    pool_table.push_back(row(CMD_SPARE_MID, 4095, -1, 1, 0, 0));
    pool_table.push_back(row(CMD_SPARE_HI, 0, 0, 1, 0, 0));
    // Top of the address space.
    pool_table.push_back(row(CMD_LOAD_IGRAD, 4095, 32767, 1, 0, 0));
    pool_table.push_back(row(CMD_READ, 4095, 0, 1, 32767, 0));
    pool_table.push_back(row(CMD_LOAD_SAMPLE, 4095, -32768, 1, 0, 0));
    pool_table.push_back(row(CMD_LOAD_OGRAD, 4095, -1, 1, 0, 0));
    pool_table.push_back(row(CMD_RUN, 0, 0, 0, 0, 0));
    foreach (pool_table[i])
      send_item(pool_table[i].it, pool_table[i].typed, pool_table[i].want);

    // A filter taller than the input makes the run a no-op that only clears the flag.
    set_pool(2, 2, 3, 2, 1, 1, 1);
    send_item(row(CMD_RUN, 0, 0, 1, 0, 0).it, 1'b1, '0);

    // Random phases until the item budget is spent.
    while (items_sent < ITEM_TARGET) begin
      steady_feed = ($urandom_range(0, 3) == 0);
      p = $urandom_range(0, 19);
      if (p == 0) begin
        saturate_phase();
      end else if (p < 4) begin
        // Invalid settings: zero size or stride, oversize plane, or oversize filter.
        case ($urandom_range(0, 4))
          0: set_pool(0, $urandom_range(1, 8), 1, 1, 1, 1, $urandom_range(0, 1));
          1: set_pool(4, 4, 1, 1, $urandom_range(0, 1) ? 0 : 1, 0, 0);
          2: set_pool(127, 65, 1, 1, 1, 1, 1);
          3: set_pool(3, 3, 3, 127, 1, 1, 0);
          default: set_pool(5, 5, 0, 5, 2, 2, 1);
        endcase
        send_cmd(CMD_RUN, 0, 0);
        send_noise($urandom_range(2, 6));
      end else begin
        if (p < 6) begin
          // Long thin planes reach the largest sizes, filters and strides cheaply.
          ih = $urandom_range(0, 1) ? 64 : 1;
          iw = (ih == 64) ? 1 : 64;
          k = $urandom_range(0, 2) == 0 ? 64 : $urandom_range(1, 64);
          set_pool(ih, iw, (ih == 64) ? k : 1, (iw == 64) ? k : 1,
                   $urandom_range(0, 1) ? 64 : $urandom_range(1, 8),
                   $urandom_range(0, 1) ? 64 : $urandom_range(1, 8), $urandom_range(0, 1));
        end else begin
          ih = $urandom_range(1, 7);
          iw = $urandom_range(1, 7);
          set_pool(ih, iw, $urandom_range(1, ih), $urandom_range(1, iw),
                   $urandom_range(0, 5) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 3),
                   $urandom_range(0, 5) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 3),
                   $urandom_range(0, 1));
        end
        load_planes();
        for (k = $urandom_range(1, 3); k > 0; k--) begin
          send_cmd(CMD_RUN, 0, 0);
          read_plane();
          send_noise($urandom_range(0, 4));
        end
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
